// ===== src/jsc_pkg.sv =====
// Package for the jump search block with occurrence count.
// Holds field widths, request codes and the controller state type.
// No dependencies.
package jsc_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int OCC_W   = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JUMP,
        ST_SCAN,
        ST_BACK,
        ST_FWD_START,
        ST_FWD,
        ST_DONE
    } state_t;

endpackage

// ===== src/jsc_req_if.sv =====
// Request channel: valid/ready handshake carrying command and value.
// Depends on jsc_pkg for field widths.
interface jsc_req_if;
    logic                                valid;
    logic                                ready;
    logic [jsc_pkg::CMD_W-1:0]           command;
    logic signed [jsc_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== src/jsc_rsp_if.sv =====
// Result channel: valid/ready handshake carrying the search outcome.
// Depends on jsc_pkg for field widths.
interface jsc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [jsc_pkg::INDEX_W-1:0]   first_index;
    logic [jsc_pkg::OCC_W-1:0]     occurrences;

    modport source (output valid, output found, output first_index, output occurrences,
                    input ready);
    modport sink   (input valid, input found, input first_index, input occurrences,
                    output ready);
endinterface

// ===== src/jsc_table.sv =====
// Value table with separate write and read ports: one write and one read per cycle, registered read data.
// Depends on jsc_pkg for the value width.
module jsc_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [jsc_pkg::VALUE_W-1:0] wr_data,
    input  logic                               rd_en,
    input  logic [AW-1:0]                      rd_addr,
    output logic signed [jsc_pkg::VALUE_W-1:0] rd_data
);

    logic signed [jsc_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/jsc_engine.sv =====
// Request decoder and search sequencer: table fill, jump walk, block scan and run count.
// Depends on jsc_pkg, jsc_req_if and jsc_rsp_if; drives the jsc_table ports.
module jsc_engine #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CW    = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    jsc_req_if.sink                            request,
    jsc_rsp_if.source                          result,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output logic signed [jsc_pkg::VALUE_W-1:0] wr_data,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  logic signed [jsc_pkg::VALUE_W-1:0] rd_data
);

    localparam int LW = CW + 1;
    localparam int QW = CW + 2;

    jsc_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [QW-1:0] sq_reg, sq_next;
    logic signed [jsc_pkg::VALUE_W-1:0] key_reg, key_next;
    logic [LW-1:0] lo_reg, lo_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] total_reg, total_next;
    logic          hit_reg, hit_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         found_reg, found_next;
    logic [jsc_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [jsc_pkg::OCC_W-1:0]    occ_reg, occ_next;

    logic          accept;
    logic [LW-1:0] n_ext;
    logic [LW-1:0] stride;
    logic [LW-1:0] bound;
    logic [LW-1:0] new_limit;
    logic [LW-1:0] new_bound;
    logic [LW-1:0] rd_idx;

    assign request.ready = (state_reg == jsc_pkg::ST_IDLE);
    assign accept        = request.valid && request.ready;

    assign n_ext     = LW'(count_reg);
    assign stride    = LW'(step_reg);
    assign bound     = (limit_reg < n_ext) ? limit_reg : n_ext;
    assign new_limit = limit_reg + stride;
    assign new_bound = (new_limit < n_ext) ? new_limit : n_ext;

    assign rd_addr = rd_idx[AW-1:0];

    assign result.valid       = out_valid_reg;
    assign result.found       = found_reg;
    assign result.first_index = index_reg;
    assign result.occurrences = occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jsc_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            sq_reg        <= QW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            sq_reg        <= sq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        lo_reg    <= lo_next;
        limit_reg <= limit_next;
        ptr_reg   <= ptr_next;
        total_reg <= total_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
        index_reg <= index_next;
        occ_reg   <= occ_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        sq_next        = sq_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        limit_next     = limit_reg;
        ptr_next       = ptr_reg;
        total_next     = total_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        index_next     = index_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && !result.ready;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = request.value;
        rd_en          = 1'b0;
        rd_idx         = '0;

        case (state_reg)
            jsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.command)
                        jsc_pkg::CMD_APPEND:
                        begin
                            // Drop the request once the table is full.
                            if (count_reg < CW'(DEPTH))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                // Track floor(sqrt(count)) with (step+1)^2 kept in sq.
                                if (sq_reg <= QW'(count_reg) + QW'(1))
                                begin
                                    step_next = step_reg + CW'(1);
                                    sq_next   = sq_reg + {1'b0, step_reg, 1'b1} + QW'(2);
                                end
                            end
                        end
                        jsc_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            step_next  = '0;
                            sq_next    = QW'(1);
                        end
                        jsc_pkg::CMD_SEARCH:
                        begin
                            key_next   = request.value;
                            lo_next    = '0;
                            limit_next = stride;
                            hit_next   = 1'b0;
                            if (count_reg == '0)
                            begin
                                state_next = jsc_pkg::ST_DONE;
                            end
                            else
                            begin
                                // Fetch the last entry of the first block.
                                rd_en      = 1'b1;
                                rd_idx     = ((stride < n_ext) ? stride : n_ext) - LW'(1);
                                state_next = jsc_pkg::ST_JUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            jsc_pkg::ST_JUMP:
            begin
                if (rd_data < key_reg)
                begin
                    lo_next    = limit_reg;
                    limit_next = new_limit;
                    if (limit_reg >= n_ext)
                    begin
                        state_next = jsc_pkg::ST_DONE;
                    end
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_idx = new_bound - LW'(1);
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = lo_reg;
                    state_next = jsc_pkg::ST_SCAN;
                end
            end

            jsc_pkg::ST_SCAN:
            begin
                if (rd_data < key_reg)
                begin
                    lo_next = lo_reg + LW'(1);
                    if (lo_reg + LW'(1) == bound)
                    begin
                        state_next = jsc_pkg::ST_DONE;
                    end
                    else
                    begin
                        rd_en  = 1'b1;
                        rd_idx = lo_reg + LW'(1);
                    end
                end
                else if (rd_data != key_reg)
                begin
                    state_next = jsc_pkg::ST_DONE;
                end
                else
                begin
                    hit_next   = 1'b1;
                    total_next = CW'(1);
                    if (lo_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = lo_reg - LW'(1);
                        ptr_next   = lo_reg - LW'(1);
                        state_next = jsc_pkg::ST_BACK;
                    end
                    else
                    begin
                        state_next = jsc_pkg::ST_FWD_START;
                    end
                end
            end

            jsc_pkg::ST_BACK:
            begin
                if (rd_data == key_reg)
                begin
                    total_next = total_reg + CW'(1);
                    if (ptr_reg != '0)
                    begin
                        rd_en    = 1'b1;
                        rd_idx   = ptr_reg - LW'(1);
                        ptr_next = ptr_reg - LW'(1);
                    end
                    else
                    begin
                        state_next = jsc_pkg::ST_FWD_START;
                    end
                end
                else
                begin
                    state_next = jsc_pkg::ST_FWD_START;
                end
            end

            jsc_pkg::ST_FWD_START:
            begin
                ptr_next = lo_reg + LW'(1);
                if (lo_reg + LW'(1) < n_ext)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = lo_reg + LW'(1);
                    state_next = jsc_pkg::ST_FWD;
                end
                else
                begin
                    state_next = jsc_pkg::ST_DONE;
                end
            end

            jsc_pkg::ST_FWD:
            begin
                if (rd_data == key_reg)
                begin
                    total_next = total_reg + CW'(1);
                    if (ptr_reg + LW'(1) < n_ext)
                    begin
                        rd_en    = 1'b1;
                        rd_idx   = ptr_reg + LW'(1);
                        ptr_next = ptr_reg + LW'(1);
                    end
                    else
                    begin
                        state_next = jsc_pkg::ST_DONE;
                    end
                end
                else
                begin
                    state_next = jsc_pkg::ST_DONE;
                end
            end

            jsc_pkg::ST_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    index_next     = hit_reg ? jsc_pkg::INDEX_W'(lo_reg) : '0;
                    occ_next       = hit_reg ? jsc_pkg::OCC_W'(total_reg) : '0;
                    state_next     = jsc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = jsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/jump_search_with_count.sv =====
// Jump search over a table of signed values with a count of equal entries.
// Append, clear and unused requests finish on acceptance; a search on an empty table goes straight to the result.
// A miss walks the blocks and then scans entries; a hit also reads each neighbor around the run,
// with one table read per cycle until the search reaches its result.
// Reset clears the entry count and block step; table contents stay undefined
// (no clearing pass). A finished result waits in an output register; a search ends once it is free.
module jump_search_with_count #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    jsc_req_if.sink    request,
    jsc_rsp_if.source  result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic signed [jsc_pkg::VALUE_W-1:0] wr_data;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic signed [jsc_pkg::VALUE_W-1:0] rd_data;

    jsc_engine #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    jsc_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The engine never writes and reads the table in the same cycle.
    a_port_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n) !(wr_en && rd_en)
    ) else $error("table written and read in the same cycle");

    // Every read is consumed in the following cycle, so no request is taken then.
    a_read_consumed: assert property (
        @(posedge clk) disable iff (!rst_n) rd_en |=> !request.ready
    ) else $error("request taken while read data pending");

    // An accepted search always leaves the block busy in the cycle after it is taken.
    a_search_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && request.command == jsc_pkg::CMD_SEARCH)
        |=> !request.ready
    ) else $error("search finished without a busy cycle");

    // Writes only happen on an accepted request.
    a_write_on_request: assert property (
        @(posedge clk) disable iff (!rst_n) wr_en |-> (request.valid && request.ready)
    ) else $error("table write without a request");

endmodule
